// ===== hw/rtl/variable_length_message_fifo_core_assert.svh =====
// ----------------------------------------------------------------------------
// variable length message fifo - assertion macros
// concurrent checks, empty bodies when built for synthesis
// ----------------------------------------------------------------------------
`ifndef VARIABLE_LENGTH_MESSAGE_FIFO_CORE_ASSERT_SVH
`define VARIABLE_LENGTH_MESSAGE_FIFO_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// condition must hold at every edge out of reset
`define VLMF_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("vlmf assertion failed");

// consequent in the same cycle as the antecedent
`define VLMF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vlmf assertion failed");

// consequent in the cycle after the antecedent
`define VLMF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vlmf assertion failed");

`else

`define VLMF_ASSERT_ALWAYS(label, clk, rst, cond)
`define VLMF_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define VLMF_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/vlmf_pkg.sv =====
// ----------------------------------------------------------------------------
// vlmf_pkg
// sizes, codes and controller/datapath interface types of the message fifo
// ----------------------------------------------------------------------------
package vlmf_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_BYTES   = 64;

  localparam int IDX_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int OFS_W     = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int MEM_DEPTH = QUEUE_DEPTH * MAX_BYTES;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int LEN_W     = 7;
  localparam int BYTE_W    = 8;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [OFS_W-1:0]  ofs_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_FULL     = 3'd1,
    STS_TOO_LONG = 3'd2,
    STS_EMPTY    = 3'd3,
    STS_TRUNC    = 3'd4
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic push;        // push beat accepted
    logic pop_start;   // pop accepted, bytes to stream
    logic pop_single;  // pop accepted, one result only (empty or zero copy)
    logic stream_load; // move the fetched byte into the output register
  } ctrl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic empty;      // no committed message
    logic copy_zero;  // pop on offer would copy no byte
    logic last_copy;  // byte being loaded is the final one of the pop
  } dp_status_t;

  function automatic addr_t slot_addr(idx_t slot, ofs_t ofs);
    slot_addr = ADDR_W'(slot) * ADDR_W'(MAX_BYTES) + ADDR_W'(ofs);
  endfunction

endpackage

// ===== hw/rtl/vlmf_ctrl.sv =====
// ----------------------------------------------------------------------------
// vlmf_ctrl
// sequencer: takes beats when idle and walks a pop through its bytes
// ----------------------------------------------------------------------------
module vlmf_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_command,
  output logic                   s_tready,
  input  vlmf_pkg::dp_status_t   sts,
  output vlmf_pkg::ctrl_cmd_t    cmd
);

  vlmf_pkg::state_t state;
  vlmf_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vlmf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      vlmf_pkg::ST_IDLE: begin
        s_tready = sts.out_free;
        if (s_tvalid && sts.out_free) begin
          if (s_command == vlmf_pkg::CMD_PUSH) begin
            cmd.push = 1'b1;
          end else if (sts.empty || sts.copy_zero) begin
            cmd.pop_single = 1'b1;
          end else begin
            cmd.pop_start = 1'b1;
            state_next    = vlmf_pkg::ST_POP;
          end
        end
      end
      vlmf_pkg::ST_POP: begin
        if (sts.out_free) begin
          cmd.stream_load = 1'b1;
          if (sts.last_copy) begin
            state_next = vlmf_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = vlmf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/vlmf_dp.sv =====
// ----------------------------------------------------------------------------
// vlmf_dp
// slot ring, staging counters, pop byte fetch and output register
// ----------------------------------------------------------------------------
`include "variable_length_message_fifo_core_assert.svh"

module vlmf_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  vlmf_pkg::ctrl_cmd_t   cmd,
  input  logic [15:0]           s_tdata,
  input  logic                  s_tlast,
  output vlmf_pkg::dp_status_t  sts,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [15:0]           m_tdata,
  output logic [3:0]            m_tuser,
  output logic                  m_tlast
);

  // byte store and read port
  vlmf_pkg::byte_t mem [vlmf_pkg::MEM_DEPTH];
  vlmf_pkg::byte_t rd_data;
  logic            wr_en;
  vlmf_pkg::addr_t wr_addr;
  logic            rd_en;
  vlmf_pkg::addr_t rd_addr;

  // ring state
  vlmf_pkg::len_t slot_len [vlmf_pkg::QUEUE_DEPTH];
  vlmf_pkg::idx_t head;
  vlmf_pkg::idx_t head_next;
  vlmf_pkg::idx_t tail;
  vlmf_pkg::cnt_t entry_count;
  logic [vlmf_pkg::IDX_W:0] tail_sum;

  // staging
  vlmf_pkg::len_t staged_len;
  logic           too_long;
  logic           full_seen;
  logic           room;
  logic           ring_full;
  logic           too_long_next;
  logic           full_seen_next;
  vlmf_pkg::len_t staged_len_next;

  // pop on offer and pop in progress
  vlmf_pkg::len_t in_max;
  vlmf_pkg::len_t max_sat;
  vlmf_pkg::len_t pop_len;
  logic           pop_trunc;
  vlmf_pkg::len_t pop_copy;
  vlmf_pkg::idx_t pop_slot;
  vlmf_pkg::len_t copy_cnt;
  vlmf_pkg::len_t full_len;
  logic           trunc;
  vlmf_pkg::len_t byte_idx;
  vlmf_pkg::len_t byte_idx_next;

  // output register
  vlmf_pkg::status_t out_status;
  logic              out_bv;
  vlmf_pkg::byte_t   out_data;
  vlmf_pkg::len_t    out_len;
  logic              out_last;
  logic              out_load;

  assign in_max = s_tdata[14:8];

  assign tail_sum = (vlmf_pkg::IDX_W + 1)'(head) + (vlmf_pkg::IDX_W + 1)'(entry_count);
  assign tail = (tail_sum >= (vlmf_pkg::IDX_W + 1)'(vlmf_pkg::QUEUE_DEPTH))
              ? vlmf_pkg::IDX_W'(tail_sum - (vlmf_pkg::IDX_W + 1)'(vlmf_pkg::QUEUE_DEPTH))
              : vlmf_pkg::IDX_W'(tail_sum);
  assign head_next = (head == vlmf_pkg::IDX_W'(vlmf_pkg::QUEUE_DEPTH - 1))
                   ? '0 : head + vlmf_pkg::IDX_W'(1);

  assign room      = staged_len < vlmf_pkg::LEN_W'(vlmf_pkg::MAX_BYTES);
  assign ring_full = entry_count >= vlmf_pkg::CNT_W'(vlmf_pkg::QUEUE_DEPTH);
  assign too_long_next   = too_long | ~room;
  assign full_seen_next  = full_seen | (room & ring_full);
  assign staged_len_next = room ? staged_len + vlmf_pkg::LEN_W'(1) : staged_len;

  assign max_sat   = (in_max > vlmf_pkg::LEN_W'(vlmf_pkg::MAX_BYTES))
                   ? vlmf_pkg::LEN_W'(vlmf_pkg::MAX_BYTES) : in_max;
  assign pop_len   = slot_len[head];
  assign pop_trunc = pop_len > max_sat;
  assign pop_copy  = pop_trunc ? max_sat : pop_len;

  assign byte_idx_next = byte_idx + vlmf_pkg::LEN_W'(1);

  assign sts.out_free  = ~m_tvalid | m_tready;
  assign sts.empty     = entry_count == '0;
  assign sts.copy_zero = pop_copy == '0;
  assign sts.last_copy = byte_idx_next == copy_cnt;

  // byte store access
  assign wr_en   = cmd.push & room & ~ring_full;
  assign wr_addr = vlmf_pkg::slot_addr(tail, staged_len[vlmf_pkg::OFS_W-1:0]);
  assign rd_en   = cmd.pop_start | (cmd.stream_load & ~sts.last_copy);
  assign rd_addr = cmd.pop_start ? vlmf_pkg::slot_addr(head, '0)
                 : vlmf_pkg::slot_addr(pop_slot, byte_idx_next[vlmf_pkg::OFS_W-1:0]);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= s_tdata[7:0];
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // commit writes the length of the tail slot
  always_ff @(posedge clk) begin
    if (cmd.push && s_tlast && !too_long_next && !full_seen_next && !ring_full) begin
      slot_len[tail] <= staged_len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      entry_count <= '0;
      staged_len  <= '0;
      too_long    <= 1'b0;
      full_seen   <= 1'b0;
    end else begin
      if (cmd.push) begin
        if (s_tlast) begin
          staged_len <= '0;
          too_long   <= 1'b0;
          full_seen  <= 1'b0;
          if (!too_long_next && !full_seen_next && !ring_full) begin
            entry_count <= entry_count + vlmf_pkg::CNT_W'(1);
          end
        end else begin
          staged_len <= staged_len_next;
          too_long   <= too_long_next;
          full_seen  <= full_seen_next;
        end
      end
      if (cmd.pop_start || (cmd.pop_single && !sts.empty)) begin
        head        <= head_next;
        entry_count <= entry_count - vlmf_pkg::CNT_W'(1);
      end
    end
  end

  // pop context
  always_ff @(posedge clk) begin
    if (cmd.pop_start) begin
      pop_slot <= head;
      copy_cnt <= pop_copy;
      full_len <= pop_len;
      trunc    <= pop_trunc;
      byte_idx <= '0;
    end else if (cmd.stream_load) begin
      byte_idx <= byte_idx_next;
    end
  end

  // output register
  assign out_load = (cmd.push & s_tlast) | cmd.pop_single | cmd.stream_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && s_tlast) begin
      out_bv   <= 1'b0;
      out_data <= '0;
      out_last <= 1'b1;
      if (too_long_next) begin
        out_status <= vlmf_pkg::STS_TOO_LONG;
        out_len    <= '0;
      end else if (full_seen_next || ring_full) begin
        out_status <= vlmf_pkg::STS_FULL;
        out_len    <= '0;
      end else begin
        out_status <= vlmf_pkg::STS_OK;
        out_len    <= staged_len_next;
      end
    end else if (cmd.pop_single) begin
      out_bv   <= 1'b0;
      out_data <= '0;
      out_last <= 1'b1;
      if (sts.empty) begin
        out_status <= vlmf_pkg::STS_EMPTY;
        out_len    <= '0;
      end else begin
        out_status <= pop_trunc ? vlmf_pkg::STS_TRUNC : vlmf_pkg::STS_OK;
        out_len    <= pop_len;
      end
    end else if (cmd.stream_load) begin
      out_status <= trunc ? vlmf_pkg::STS_TRUNC : vlmf_pkg::STS_OK;
      out_bv     <= 1'b1;
      out_data   <= rd_data;
      out_len    <= full_len;
      out_last   <= sts.last_copy;
    end
  end

  assign m_tdata = {1'b0, out_len, out_data};
  assign m_tuser = {out_bv, out_status};
  assign m_tlast = out_last;

  `VLMF_ASSERT_ALWAYS(a_count_bound, clk, rst, entry_count <= vlmf_pkg::CNT_W'(vlmf_pkg::QUEUE_DEPTH))
  `VLMF_ASSERT_IMPLY(a_pop_not_empty, clk, rst, cmd.pop_start, entry_count != '0 && pop_copy != '0)
  `VLMF_ASSERT_IMPLY(a_stream_in_range, clk, rst, cmd.stream_load, byte_idx < copy_cnt)
  `VLMF_ASSERT_NEXT(a_stream_step, clk, rst, cmd.stream_load && !sts.last_copy, byte_idx == $past(byte_idx) + vlmf_pkg::LEN_W'(1))

endmodule

// ===== hw/rtl/variable_length_message_fifo_core.sv =====
// ----------------------------------------------------------------------------
// variable_length_message_fifo_core
// ring of fixed slots holding whole byte messages, pushed and popped as beats
// ----------------------------------------------------------------------------
// Each input beat is either a push of one message byte (tuser = 0, tlast on the
// final byte) or a pop request (tuser = 1) carrying a maximum length. A push
// beat is taken every cycle while the output register is free; a non-final
// byte gives no result and the final byte gives one status beat (ok with the
// committed length, full dropped or too long dropped). A pop of n bytes first
// fetches the first byte from the registered read port of the byte store, then
// gives one byte beat per cycle while the output register is free, tlast on the
// last one. An empty ring, or a pop that copies no byte, gives a single beat.
// No further beat is taken while a pop is streaming. The stores need no
// clearing after reset, so the block is ready as soon as reset is released.
// Only the head slot is read, and only slots that have been committed.
// ----------------------------------------------------------------------------
module variable_length_message_fifo_core (
  input  logic        clk,
  input  logic        rst,
  // request side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // data_byte [7:0], max_len [14:8], zero [15]
  input  logic [0:0]  s_tuser,   // command [0]
  input  logic        s_tlast,   // last_byte
  // result side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // data_out [7:0], message_length [14:8], zero [15]
  output logic [3:0]  m_tuser,   // status [2:0], byte_valid [3]
  output logic        m_tlast    // last_result
);

  // controller to datapath commands and datapath status
  vlmf_pkg::ctrl_cmd_t  cmd;
  vlmf_pkg::dp_status_t sts;

  // sequencer: accepts beats in idle, steps through pop bytes
  vlmf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_command (s_tuser[0]),
    .s_tready  (s_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // byte store, slot lengths, ring pointers, staging and output register
  vlmf_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the message fifo: a directed table of push and pop
// beats, then randomised message traffic in three back-pressure phases, with
// result beats checked against typed-in beats or a behavioural ring model
// ----------------------------------------------------------------------------
module tb_top;

  localparam int QUIET_LIMIT  = 5000;  // cycles with no beat on either side
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 20;    // settle time after the last result
  localparam int N_STIM_ROWS  = 17;

  typedef enum logic [1:0] {
    LAST_NONE,  // no byte of the row is marked last
    LAST_END,   // final byte of the row is marked last
    LAST_EACH   // every byte is a one-byte message
  } last_mode_t;

  typedef struct {
    logic [2:0]      status;
    logic            byte_valid;
    vlmf_pkg::byte_t data_out;
    vlmf_pkg::len_t  length;
    logic            last;
  } fifo_beat_t;

  typedef struct {
    logic            cmd;
    vlmf_pkg::byte_t data;
    last_mode_t      last_mode;
    vlmf_pkg::len_t  max_len;
    int              reps;
    bit              typed;   // result typed in below rather than predicted
    logic [2:0]      status;
    vlmf_pkg::len_t  length;
  } stim_row_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;   // data_byte [7:0], max_len [14:8], zero [15]
  logic [0:0]  s_tuser  = '0;   // command [0]
  logic        s_tlast  = 1'b0; // last_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;         // data_out [7:0], message_length [14:8], zero [15]
  logic [3:0]  m_tuser;         // status [2:0], byte_valid [3]
  logic        m_tlast;         // last_result

  variable_length_message_fifo_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #10 clk = ~clk;

  // ring model: slot store, head, occupancy and the message being staged
  vlmf_pkg::byte_t ring_bytes [vlmf_pkg::QUEUE_DEPTH][vlmf_pkg::MAX_BYTES];
  int    ring_lens  [vlmf_pkg::QUEUE_DEPTH];
  int    head_slot    = 0;
  int    stored_msgs  = 0;
  int    staged_bytes = 0;
  bit    overlong     = 1'b0;
  bit    full_drop    = 1'b0;

  fifo_beat_t step_beats [$];      // beats caused by the latest input beat
  fifo_beat_t expected_beats [$];  // oldest first
  fifo_beat_t oldest_beat;
  fifo_beat_t unused_beat;

  int src_idle_pct = 16;
  int snk_idle_pct = 69;
  int items_sent   = 0;
  int errors       = 0;
  int hold_tickets = 0;
  int hold_served  = 0;
  int hold_left    = 0;
  int quiet_cycles = 0;

  stim_row_t stim_table [N_STIM_ROWS];

  function automatic fifo_beat_t make_beat(logic [2:0] status, logic valid,
                                           vlmf_pkg::byte_t data,
                                           vlmf_pkg::len_t length, logic last);
    fifo_beat_t b;
    b.status     = status;
    b.byte_valid = valid;
    b.data_out   = data;
    b.length     = length;
    b.last       = last;
    return b;
  endfunction

  // one pushed byte: stage it, and on the final byte commit or drop the message
  function automatic void ring_push(vlmf_pkg::byte_t data, logic final_byte);
    int         tail;
    int         committed;
    logic [2:0] status;
    tail      = (head_slot + stored_msgs) % vlmf_pkg::QUEUE_DEPTH;
    committed = 0;
    if (staged_bytes >= vlmf_pkg::MAX_BYTES) begin
      overlong = 1'b1;
    end else begin
      // a full ring means the tail slot is the head slot, so the byte is lost
      if (stored_msgs >= vlmf_pkg::QUEUE_DEPTH) full_drop = 1'b1;
      else ring_bytes[tail][staged_bytes] = data;
      staged_bytes++;
    end
    if (!final_byte) return;
    if (overlong) begin
      status = vlmf_pkg::STS_TOO_LONG;
    end else if (full_drop || stored_msgs >= vlmf_pkg::QUEUE_DEPTH) begin
      status = vlmf_pkg::STS_FULL;
    end else begin
      ring_lens[tail] = staged_bytes;
      stored_msgs++;
      committed = staged_bytes;
      status    = vlmf_pkg::STS_OK;
    end
    staged_bytes = 0;
    overlong     = 1'b0;
    full_drop    = 1'b0;
    step_beats.push_back(make_beat(status, 1'b0, 8'h00, vlmf_pkg::len_t'(committed), 1'b1));
  endfunction

  // pop the head message, clipped to the requested length
  function automatic void ring_pop(vlmf_pkg::len_t max_len);
    int         limit;
    int         stored_len;
    int         copy;
    bit         trunc;
    logic [2:0] status;
    if (stored_msgs == 0) begin
      step_beats.push_back(make_beat(vlmf_pkg::STS_EMPTY, 1'b0, 8'h00, '0, 1'b1));
      return;
    end
    limit      = (max_len > vlmf_pkg::MAX_BYTES) ? vlmf_pkg::MAX_BYTES : int'(max_len);
    stored_len = ring_lens[head_slot];
    trunc      = stored_len > limit;
    copy       = trunc ? limit : stored_len;
    status     = trunc ? vlmf_pkg::STS_TRUNC : vlmf_pkg::STS_OK;
    if (copy == 0) begin
      step_beats.push_back(make_beat(status, 1'b0, 8'h00, vlmf_pkg::len_t'(stored_len),
                                     1'b1));
    end else begin
      for (int k = 0; k < copy; k++)
        step_beats.push_back(make_beat(status, 1'b1, ring_bytes[head_slot][k],
                                       vlmf_pkg::len_t'(trunc ? stored_len : copy),
                                       k == copy - 1));
    end
    head_slot = (head_slot + 1) % vlmf_pkg::QUEUE_DEPTH;
    stored_msgs--;
  endfunction

  // offer one request beat with random gaps ahead of it; on acceptance run the
  // ring model and queue what it predicts (or the typed-in beat)
  task automatic send_item(logic cmd, vlmf_pkg::byte_t data, logic final_byte,
                           vlmf_pkg::len_t max_len, bit typed, fifo_beat_t typed_beat);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {1'b0, max_len, data};
    s_tlast  <= final_byte;
    do @(posedge clk); while (!s_tready);
    step_beats.delete();
    if (cmd == vlmf_pkg::CMD_PUSH) ring_push(data, final_byte);
    else ring_pop(max_len);
    if (typed && step_beats.size() != 0) begin
      expected_beats.push_back(typed_beat);
    end else begin
      foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
    end
    items_sent++;
  endtask

  // random pop; mostly legal lengths, sometimes zero or beyond the slot size
  task automatic random_pop();
    vlmf_pkg::len_t max_len;
    max_len = ($urandom_range(3) == 0) ? vlmf_pkg::len_t'($urandom_range(127))
                                       : vlmf_pkg::len_t'($urandom_range(64, 1));
    send_item(vlmf_pkg::CMD_POP, vlmf_pkg::byte_t'($urandom), 1'($urandom), max_len,
              1'b0, unused_beat);
  endtask

  // one whole message of random bytes, now and then interrupted by a pop
  task automatic random_message(int n_bytes);
    for (int k = 0; k < n_bytes; k++) begin
      if ($urandom_range(19) == 0) random_pop();
      send_item(vlmf_pkg::CMD_PUSH, vlmf_pkg::byte_t'($urandom), k == n_bytes - 1,
                vlmf_pkg::len_t'($urandom), 1'b0, unused_beat);
    end
  endtask

  task automatic random_phase(int n_items, int push_pct);
    int start;
    int pick;
    int n_bytes;
    start = items_sent;
    while (items_sent - start < n_items) begin
      if ($urandom_range(99) < push_pct) begin
        pick = $urandom_range(19);
        // short messages mostly, now and then a longer one
        if (pick < 18) n_bytes = $urandom_range(6, 1);
        else n_bytes = $urandom_range(20, 7);
        random_message(n_bytes);
      end else begin
        random_pop();
      end
    end
  endtask

  // hold the request side idle until every predicted beat has arrived
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  // result side: check each accepted beat, then choose the next tready
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected result beat: status %0d valid %0d data %02h length %0d last %0d",
                   $time, m_tuser[2:0], m_tuser[3], m_tdata[7:0], m_tdata[14:8], m_tlast);
          errors++;
        end else begin
          oldest_beat = expected_beats.pop_front();
          if ({oldest_beat.status, oldest_beat.byte_valid, oldest_beat.data_out,
               oldest_beat.length, oldest_beat.last} !==
              {m_tuser[2:0], m_tuser[3], m_tdata[7:0], m_tdata[14:8], m_tlast}) begin
            $display("%0t: mismatch: expected status %0d valid %0d data %02h length %0d last %0d",
                     $time, oldest_beat.status, oldest_beat.byte_valid, oldest_beat.data_out,
                     oldest_beat.length, oldest_beat.last);
            $display("%0t:           actual   status %0d valid %0d data %02h length %0d last %0d",
                     $time, m_tuser[2:0], m_tuser[3], m_tdata[7:0], m_tdata[14:8], m_tlast);
            errors++;
          end
        end
      end
      // a new hold request starts a long stretch with tready low
      if (hold_tickets != hold_served) begin
        hold_served = hold_tickets;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // watchdog: ends the run when no beat has moved for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: watchdog: no beat moved for %0d cycles", $time, QUIET_LIMIT);
      $display("** variable_length_message_fifo_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    fifo_beat_t typed_beat;
    logic       row_last;

    // cmd, data, last mode, max_len, reps, typed, status, length
    stim_table = '{
      // empty after reset
      '{vlmf_pkg::CMD_POP,  8'h00, LAST_NONE, 7'd1,   1,  1'b1, vlmf_pkg::STS_EMPTY, 7'd0},
      // all-zero byte
      '{vlmf_pkg::CMD_PUSH, 8'h00, LAST_END,  7'd0,   1,  1'b1, vlmf_pkg::STS_OK,    7'd1},
      // all-ones byte
      '{vlmf_pkg::CMD_PUSH, 8'hff, LAST_END,  7'd127, 1,  1'b1, vlmf_pkg::STS_OK,    7'd1},
      // exact fit
      '{vlmf_pkg::CMD_POP,  8'hff, LAST_NONE, 7'd1,   1,  1'b0, vlmf_pkg::STS_OK,    7'd0},
      // zero max length
      '{vlmf_pkg::CMD_POP,  8'h00, LAST_NONE, 7'd0,   1,  1'b1, vlmf_pkg::STS_TRUNC, 7'd1},
      '{vlmf_pkg::CMD_PUSH, 8'h10, LAST_END,  7'd0,   5,  1'b1, vlmf_pkg::STS_OK,    7'd5},
      // staging, no result
      '{vlmf_pkg::CMD_PUSH, 8'h20, LAST_NONE, 7'd0,   3,  1'b0, vlmf_pkg::STS_OK,    7'd0},
      // truncated, mid-stage
      '{vlmf_pkg::CMD_POP,  8'h00, LAST_NONE, 7'd2,   1,  1'b0, vlmf_pkg::STS_OK,    7'd0},
      '{vlmf_pkg::CMD_PUSH, 8'h23, LAST_END,  7'd0,   1,  1'b1, vlmf_pkg::STS_OK,    7'd4},
      // max length saturates
      '{vlmf_pkg::CMD_POP,  8'h00, LAST_NONE, 7'd127, 1,  1'b0, vlmf_pkg::STS_OK,    7'd0},
      // fill the ring
      '{vlmf_pkg::CMD_PUSH, 8'h80, LAST_EACH, 7'd0,   16, 1'b0, vlmf_pkg::STS_OK,    7'd0},
      // full on last byte
      '{vlmf_pkg::CMD_PUSH, 8'h40, LAST_END,  7'd0,   1,  1'b1, vlmf_pkg::STS_FULL,  7'd0},
      // byte lost while full
      '{vlmf_pkg::CMD_PUSH, 8'h41, LAST_NONE, 7'd0,   1,  1'b0, vlmf_pkg::STS_OK,    7'd0},
      // frees a slot
      '{vlmf_pkg::CMD_POP,  8'h00, LAST_NONE, 7'd64,  1,  1'b0, vlmf_pkg::STS_OK,    7'd0},
      // still dropped
      '{vlmf_pkg::CMD_PUSH, 8'h43, LAST_END,  7'd0,   1,  1'b1, vlmf_pkg::STS_FULL,  7'd0},
      // full again
      '{vlmf_pkg::CMD_PUSH, 8'h44, LAST_END,  7'd0,   1,  1'b1, vlmf_pkg::STS_OK,    7'd1},
      // too long beats full
      '{vlmf_pkg::CMD_PUSH, 8'h00, LAST_END,  7'd0,   65, 1'b1, vlmf_pkg::STS_TOO_LONG, 7'd0}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed table, sender idle 16 %, receiver idle 69 %
    foreach (stim_table[r]) begin
      for (int k = 0; k < stim_table[r].reps; k++) begin
        row_last = (stim_table[r].last_mode == LAST_EACH) ||
                   (stim_table[r].last_mode == LAST_END && k == stim_table[r].reps - 1);
        typed_beat = make_beat(stim_table[r].status, 1'b0, 8'h00, stim_table[r].length, 1'b1);
        send_item(stim_table[r].cmd, stim_table[r].data + vlmf_pkg::byte_t'(k), row_last,
                  stim_table[r].max_len, stim_table[r].typed, typed_beat);
      end
    end
    random_phase(6, 30);

    // sender pauses until everything is out, then the idling swaps round
    wait_for_results();
    src_idle_pct = 69;
    snk_idle_pct = 16;
    random_phase(6, 35);

    // no idling; a long receiver hold-off fills the block and stalls requests
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_tickets++;
    random_phase(6, 60);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("** variable_length_message_fifo_core: PASSED **");
    end else begin
      $display("** variable_length_message_fifo_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/vlmf_pkg.sv
hw/rtl/vlmf_ctrl.sv
hw/rtl/vlmf_dp.sv
hw/rtl/variable_length_message_fifo_core.sv
tb/tb_top.sv
